### hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/lhp_pkg.sv
`default_nettype none

package lhp_pkg;

    localparam int BUCKET_COUNT = 10;
    localparam int BIDX_W       = $clog2(BUCKET_COUNT);
    localparam int S_TDATA_W    = 56;
    localparam int M_TDATA_W    = 192;
    localparam int ALU_W        = 64;

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    localparam logic [16:0] Q16_ONE = 17'h10000;
    localparam logic [62:0] SUM_MAX = {63{1'b1}};
    localparam logic [31:0] U32_MAX = {32{1'b1}};

    typedef logic [BIDX_W-1:0] bidx_t;

    typedef struct packed {
        logic             op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             carry;
        logic             lt;
    } alu_rsp_t;

    // Upper bound of each finite bucket in microseconds.
    function automatic logic [30:0] bound_us(input logic [3:0] idx);
        logic [30:0] b;
        case (idx)
            4'd0:    b = 31'd250;
            4'd1:    b = 31'd500;
            4'd2:    b = 31'd1000;
            4'd3:    b = 31'd2000;
            4'd4:    b = 31'd4000;
            4'd5:    b = 31'd8000;
            4'd6:    b = 31'd16670;
            4'd7:    b = 31'd33000;
            4'd8:    b = 31'd50000;
            4'd9:    b = 31'd100000;
            4'd10:   b = 31'd200000;
            4'd11:   b = 31'd400000;
            4'd12:   b = 31'd800000;
            4'd13:   b = 31'd1600000;
            4'd14:   b = 31'd3200000;
            default: b = 31'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lhp_alu.sv
`default_nettype none

module lhp_alu (
    input  wire lhp_pkg::alu_req_t req,
    output lhp_pkg::alu_rsp_t      rsp
);
    import lhp_pkg::*;

    logic [ALU_W-1:0] b_eff;
    logic [ALU_W:0]   full;

    assign b_eff = (req.op == ALU_SUB) ? ~req.b : req.b;
    assign full  = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, req.op};

    assign rsp.res   = full[ALU_W-1:0];
    assign rsp.carry = full[ALU_W];
    // A subtraction without carry out means a is below b.
    assign rsp.lt    = (req.op == ALU_SUB) && !full[ALU_W];

endmodule

`default_nettype wire

### hw/rtl/latency_histogram_percentile.sv
// Sequence: a clear or an unused command goes straight to the output state; a record passes
// through ST_SUM, ST_MAX and ST_FIND (the bucket search compares one bound a cycle), and a
// query passes through ST_RANK, which goes straight to ST_OUT on an empty histogram, else
// through ST_SCAN (the tally scan takes one bucket a cycle) before ST_OUT offers the result.
// Throughput: one item at a time; the next item is accepted only once the state is idle and
// the previous result has been taken.
// Reset: synchronous active-low aresetn zeroes all statistics and empties the output.
`default_nettype none

module latency_histogram_percentile (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: sample_us[31:0], percentile_q16[48:32], zero fill.
    input  wire [lhp_pkg::S_TDATA_W-1:0]    s_tdata,
    // Fields from bit 0: cmd[1:0].
    input  wire [1:0]                       s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // Fields from bit 0: sample_count[31:0], total_us[94:32], max_us[125:95],
    // last_us[156:126], percentile_us[187:157], zero fill.
    output logic [lhp_pkg::M_TDATA_W-1:0]   m_tdata
);
    import lhp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_MAX  = 3'd2;
    localparam logic [2:0] ST_FIND = 3'd3;
    localparam logic [2:0] ST_RANK = 3'd4;
    localparam logic [2:0] ST_SCAN = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam bidx_t LAST_IDX = BIDX_W'(BUCKET_COUNT - 1);

    logic [2:0]  state_reg, state_next;
    logic [30:0] samp_reg, samp_next;
    logic [16:0] pct_reg, pct_next;
    bidx_t       idx_reg, idx_next;
    logic [31:0] rem_reg, rem_next;
    logic [30:0] ans_reg, ans_next;
    logic [31:0] tally_reg, tally_next;
    logic [62:0] sum_reg, sum_next;
    logic [30:0] max_reg, max_next;
    logic [30:0] last_reg, last_next;
    logic [31:0] bucket_reg [BUCKET_COUNT];
    logic [31:0] bucket_next [BUCKET_COUNT];
    logic        m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;
    logic [30:0] cur_bound;
    logic [31:0] cur_bucket;
    logic [47:0] rank_prod;

    lhp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign cur_bound  = bound_us(4'(idx_reg));
    assign cur_bucket = bucket_reg[idx_reg];
    assign rank_prod  = pct_reg[15:0] * tally_reg;

    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        samp_next    = samp_reg;
        pct_next     = pct_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        ans_next     = ans_reg;
        tally_next   = tally_reg;
        sum_next     = sum_reg;
        max_next     = max_reg;
        last_next    = last_reg;
        bucket_next  = bucket_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        alu_req.op   = ALU_SUB;
        alu_req.a    = '0;
        alu_req.b    = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    samp_next = s_tdata[31] ? 31'd0 : s_tdata[30:0];
                    pct_next  = (s_tdata[48:32] > Q16_ONE) ? Q16_ONE : s_tdata[48:32];
                    ans_next  = '0;
                    case (s_tuser)
                        CMD_RECORD: state_next = ST_SUM;
                        CMD_QUERY:  state_next = ST_RANK;
                        CMD_CLEAR: begin
                            tally_next = '0;
                            sum_next   = '0;
                            max_next   = '0;
                            last_next  = '0;
                            for (int i = 0; i < BUCKET_COUNT; i++) begin
                                bucket_next[i] = '0;
                            end
                            state_next = ST_OUT;
                        end
                        default:    state_next = ST_OUT;
                    endcase
                end
            end
            ST_SUM: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = {1'b0, sum_reg};
                alu_req.b  = {33'd0, samp_reg};
                sum_next   = alu_rsp.res[63] ? SUM_MAX : alu_rsp.res[62:0];
                tally_next = (tally_reg == U32_MAX) ? tally_reg : tally_reg + 32'd1;
                last_next  = samp_reg;
                state_next = ST_MAX;
            end
            ST_MAX: begin
                alu_req.a  = {33'd0, max_reg};
                alu_req.b  = {33'd0, samp_reg};
                if (alu_rsp.lt) begin
                    max_next = samp_reg;
                end
                idx_next   = '0;
                state_next = ST_FIND;
            end
            ST_FIND: begin
                alu_req.a = {33'd0, samp_reg};
                alu_req.b = {33'd0, cur_bound};
                if (alu_rsp.lt || idx_reg == LAST_IDX) begin
                    if (cur_bucket != U32_MAX) begin
                        bucket_next[idx_reg] = cur_bucket + 32'd1;
                    end
                    state_next = ST_OUT;
                end else begin
                    idx_next = idx_reg + BIDX_W'(1);
                end
            end
            ST_RANK: begin
                idx_next = '0;
                if (tally_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    rem_next   = pct_reg[16] ? tally_reg - 32'd1 : rank_prod[47:16];
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // The remaining rank falls in this bucket once it is below the bucket tally.
                alu_req.a = {32'd0, rem_reg};
                alu_req.b = {32'd0, cur_bucket};
                if (alu_rsp.lt) begin
                    ans_next   = (idx_reg == LAST_IDX) ? max_reg : cur_bound;
                    state_next = ST_OUT;
                end else if (idx_reg == LAST_IDX) begin
                    ans_next   = max_reg;
                    state_next = ST_OUT;
                end else begin
                    rem_next = alu_rsp.res[31:0];
                    idx_next = idx_reg + BIDX_W'(1);
                end
            end
            ST_OUT: begin
                m_data_next  = {4'd0, ans_reg, last_reg, max_reg, sum_reg, tally_reg};
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tally_reg   <= '0;
            sum_reg     <= '0;
            max_reg     <= '0;
            last_reg    <= '0;
            for (int i = 0; i < BUCKET_COUNT; i++) begin
                bucket_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            tally_reg   <= tally_next;
            sum_reg     <= sum_next;
            max_reg     <= max_next;
            last_reg    <= last_next;
            bucket_reg  <= bucket_next;
        end
    end

    always_ff @(posedge aclk) begin
        samp_reg   <= samp_next;
        pct_reg    <= pct_next;
        idx_reg    <= idx_next;
        rem_reg    <= rem_next;
        ans_reg    <= ans_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

### hw/rtl/lhp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module lhp_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire [lhp_pkg::S_TDATA_W-1:0]  s_tdata,
    input wire [1:0]                     s_tuser,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [lhp_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lhp_pkg::*;

    // The block takes no new item while a result is still waiting.
    `ASSERT_IMPL(a_no_accept_with_result, aclk, aresetn, m_tvalid, !s_tready)
    // An accepted item keeps the block busy in the following cycle.
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A stalled result stays offered.
    `ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // With no samples recorded, every percentile answer is zero.
    `ASSERT_IMPL(a_empty_answer_zero, aclk, aresetn, m_tvalid && (m_tdata[31:0] == 32'd0),
        m_tdata[187:157] == 31'd0)

endmodule

bind latency_histogram_percentile lhp_checker u_lhp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
